/* design/sdx_pkg.sv */
// Shared types, constants and the letter code table for the soundex key encoder.
`default_nettype none
package sdx_pkg;

    localparam int KEY_LENGTH_DEF = 4;
    localparam int OUT_CHARS      = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_UC_A  = 8'h41;
    localparam logic [7:0] ASCII_UC_Z  = 8'h5A;
    localparam logic [7:0] ASCII_LC_A  = 8'h61;
    localparam logic [7:0] ASCII_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // classified word handed from front to back
    typedef struct packed {
        logic       present;
        logic       last;
        logic       letter;
        logic [7:0] upper;
        logic [2:0] code;
    } t_item;

    function automatic logic [2:0] letter_code(input logic [4:0] idx);
        logic [2:0] c;
        unique case (idx)
            5'd1, 5'd5, 5'd15, 5'd21:                         c = 3'd1;
            5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: c = 3'd2;
            5'd3, 5'd19:                                      c = 3'd3;
            5'd11:                                            c = 3'd4;
            5'd12, 5'd13:                                     c = 3'd5;
            5'd17:                                            c = 3'd6;
            default:                                          c = 3'd0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* design/sdx_front.sv */
// Front stage: takes input words, folds case, classifies letters, registers the result.
`default_nettype none
module sdx_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire        [7:0] i_byte,
    input  wire              i_present,
    input  wire              i_last,
    output logic             o_valid,
    input  wire              i_ready,
    output sdx_pkg::t_item   o_item
);

    logic           r_valid;
    sdx_pkg::t_item r_item;
    sdx_pkg::t_item n_item;
    logic [7:0]     up;
    logic [7:0]     ofs;

    always_comb begin
        if (i_byte >= sdx_pkg::ASCII_LC_A && i_byte <= sdx_pkg::ASCII_LC_Z) begin
            up = i_byte - sdx_pkg::CASE_OFFSET;
        end else begin
            up = i_byte;
        end
        ofs            = up - sdx_pkg::ASCII_UC_A;
        n_item.present = i_present;
        n_item.last    = i_last;
        n_item.letter  = (up >= sdx_pkg::ASCII_UC_A) && (up <= sdx_pkg::ASCII_UC_Z);
        n_item.upper   = up;
        n_item.code    = sdx_pkg::letter_code(ofs[4:0]);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

/* design/sdx_queue.sv */
// Short queue of classified words between the front and back stages.
`default_nettype none
module sdx_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    output logic             o_ready,
    input  sdx_pkg::t_item   i_item,
    input  wire              i_pop,
    output logic             o_valid,
    output sdx_pkg::t_item   o_item
);

    localparam int PW = (sdx_pkg::QUEUE_DEPTH > 1) ? $clog2(sdx_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(sdx_pkg::QUEUE_DEPTH + 1);

    sdx_pkg::t_item r_mem [sdx_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_ready = r_count < CW'(sdx_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(sdx_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(sdx_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

/* design/sdx_back.sv */
// Back stage: builds the key from classified words and holds the result word.
`default_nettype none
module sdx_back #(
    parameter int KEY_LENGTH = sdx_pkg::KEY_LENGTH_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_pop,
    input  sdx_pkg::t_item   i_item,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [31:0]      o_data,
    output logic             o_empty
);

    localparam int CW = $clog2(KEY_LENGTH + 1);

    logic [7:0]    r_store [KEY_LENGTH];
    logic [7:0]    n_store [KEY_LENGTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [2:0]    r_prev;
    logic [2:0]    n_prev;
    logic          r_saw;
    logic          n_saw;
    logic          r_out_valid;
    logic [31:0]   r_out_data;
    logic          r_out_empty;
    logic          out_free;
    logic          finish;
    logic [7:0]    key_char [sdx_pkg::OUT_CHARS];
    logic [31:0]   n_data;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_valid && (!i_item.last || out_free);
    assign finish   = o_pop && i_item.last;

    always_comb begin
        n_store = r_store;
        n_count = r_count;
        n_prev  = r_prev;
        n_saw   = r_saw;
        if (o_pop && i_item.present) begin
            n_saw = 1'b1;
            if (i_item.letter && r_count < CW'(KEY_LENGTH)) begin
                if (r_count == '0) begin
                    n_store[0] = i_item.upper;
                    n_count    = CW'(1);
                    n_prev     = i_item.code;
                end else if (i_item.code != r_prev) begin
                    if (i_item.code != 3'd0) begin
                        for (int i = 0; i < KEY_LENGTH; i++) begin
                            if (r_count == CW'(i)) begin
                                n_store[i] = sdx_pkg::ASCII_ZERO + {5'd0, i_item.code};
                            end
                        end
                        n_count = r_count + 1'b1;
                    end
                    n_prev = i_item.code;
                end
            end
        end
    end

    genvar j;
    generate
        for (j = 0; j < sdx_pkg::OUT_CHARS; j++) begin : g_char
            if (j < KEY_LENGTH) begin : g_key
                assign key_char[j] = (n_count > CW'(j)) ? n_store[j] : sdx_pkg::ASCII_ZERO;
            end else begin : g_pad
                assign key_char[j] = sdx_pkg::ASCII_ZERO;
            end
        end
    endgenerate

    assign n_data = n_saw ? {key_char[3], key_char[2], key_char[1], key_char[0]} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prev  <= '0;
            r_saw   <= 1'b0;
        end else if (finish) begin
            r_count <= '0;
            r_prev  <= '0;
            r_saw   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_prev  <= n_prev;
            r_saw   <= n_saw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_data  <= n_data;
            r_out_empty <= !n_saw;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_empty = r_out_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(KEY_LENGTH))
        else $error("key count beyond key length");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_count == '0) && (r_prev == 3'd0) && !r_saw)
        else $error("key state not cleared after end of string");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> r_out_valid && $stable(r_out_data))
        else $error("stalled result word lost");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_empty |-> r_out_data == 32'd0)
        else $error("empty result carries key characters");

    a_no_pop_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.last |-> out_free)
        else $error("end word taken while result register busy");

endmodule
`default_nettype wire

/* design/soundex_key_encoder_unit.sv */
// Soundex key encoder top level: streaming input of string bytes, one key word per string.
//
// Slave channel: one word per string byte. tdata[7:0] is the byte, tdata[8] flags that
// the byte is present (clear for an end-only word), tlast marks the end of the string.
// Master channel: one word per string, sent for the word carrying tlast.
// tdata holds the four key characters, first character in the lowest byte; tuser is
// set when the string held no bytes at all, and tdata is then all zeros.
// Throughput: one word per cycle, sustained, as long as results are taken.
// The end word passes the front classify register, then the queue storage, and the
// back key update then writes the result into the output register.
// The key length is set by KEY_LENGTH (2 to 8); only the first four characters are
// sent, shorter keys are padded with ASCII zero.
// Reset clears the queue, the key state and the output valid; no clearing pass.
// If the receiver stalls, the result word holds, the back stage keeps consuming
// non-end words, and the input stalls once the queue and front register fill.
`default_nettype none
module soundex_key_encoder_unit #(
    parameter int KEY_LENGTH = sdx_pkg::KEY_LENGTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [15:0] i_s_axis_tdata,  // [7:0] char_byte, [8] char_present, rest zero
    input  wire         i_s_axis_tlast,  // end_of_string
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // [7:0] key_letter, [15:8] key_digit_one,
                                         // [23:16] key_digit_two, [31:24] key_digit_three
    output logic        o_m_axis_tuser   // empty_input
);

    logic           front_valid;
    logic           queue_ready;
    sdx_pkg::t_item front_item;
    logic           queue_valid;
    sdx_pkg::t_item queue_item;
    logic           back_pop;

    sdx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata[7:0]),
        .i_present (i_s_axis_tdata[8]),
        .i_last    (i_s_axis_tlast),
        .o_valid   (front_valid),
        .i_ready   (queue_ready),
        .o_item    (front_item)
    );

    sdx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .i_item  (front_item),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    sdx_back #(
        .KEY_LENGTH (KEY_LENGTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .o_pop   (back_pop),
        .i_item  (queue_item),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_empty (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

/* tb/sv/tb_soundex_key_encoder_unit.sv */
// Self-checking testbench for the soundex key encoder: predicts each key and checks it.
`default_nettype none
package tb_soundex_key_pkg;
    import sdx_pkg::*;

    localparam int KEY_LEN = KEY_LENGTH_DEF;

    // code per letter, A first
    localparam logic [2:0] SOUNDEX_CODES [0:25] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd5,
        3'd5, 3'd0, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd2
    };

    typedef struct packed {
        logic [3:0][7:0] chars;
        logic            empty;
    } t_key_word;

    class soundex_key_checker;
        logic [7:0]  key_chars [KEY_LEN];
        int unsigned held;
        logic [2:0]  last_code;
        bit          got_byte;
        t_key_word   pending_keys [$];
        int unsigned bad_keys;

        function new();
            clear();
            bad_keys = 0;
        endfunction

        function void clear();
            foreach (key_chars[i]) key_chars[i] = 8'h00;
            held      = 0;
            last_code = 3'd0;
            got_byte  = 1'b0;
        endfunction

        function void note_word(logic [7:0] b, logic present, logic last);
            logic [7:0] up;
            logic [2:0] code;
            t_key_word  k;
            if (present) begin
                got_byte = 1'b1;
                up = b;
                if (b >= ASCII_LC_A && b <= ASCII_LC_Z) up = b - CASE_OFFSET;
                if (up >= ASCII_UC_A && up <= ASCII_UC_Z && held < KEY_LEN) begin
                    code = SOUNDEX_CODES[up - ASCII_UC_A];
                    if (held == 0) begin
                        key_chars[0] = up;
                        held         = 1;
                        last_code    = code;
                    end else if (code != last_code) begin
                        if (code != 3'd0) begin
                            key_chars[held] = ASCII_ZERO + {5'd0, code};
                            held++;
                        end
                        last_code = code;
                    end
                end
            end
            if (!last) return;
            k = '0;
            if (!got_byte) begin
                k.empty = 1'b1;
            end else begin
                for (int j = 0; j < 4; j++)
                    k.chars[j] = (j < held) ? key_chars[j] : ASCII_ZERO;
            end
            pending_keys.push_back(k);
            clear();
        endfunction

        function void check_key(logic [31:0] data, logic user);
            t_key_word want;
            bit        ok;
            if (pending_keys.size() == 0) begin
                if (bad_keys < 10) $display("unexpected key word %h, empty %b", data, user);
                bad_keys++;
                return;
            end
            want = pending_keys.pop_front();
            ok = (want.empty == user);
            for (int j = 0; j < 4; j++)
                if (want.chars[j] !== data[8*j +: 8]) ok = 1'b0;
            if (!ok) begin
                if (bad_keys < 10)
                    $display("key mismatch: expected %h empty %b, got %h empty %b",
                             want.chars, want.empty, data, user);
                bad_keys++;
            end
        endfunction
    endclass
endpackage

module tb_soundex_key_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sdx_pkg::*;
    import tb_soundex_key_pkg::*;

    localparam int WORD_TARGET    = 1700;
    localparam int HOLD_OFF       = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;   // [7:0] char_byte, [8] char_present, rest zero
    logic        i_s_axis_tlast;   // end_of_string
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // [7:0] key_letter, [15:8] key_digit_one,
                                   // [23:16] key_digit_two, [31:24] key_digit_three
    logic        o_m_axis_tuser;   // empty_input

    soundex_key_checker keys = new();
    int unsigned        words_sent = 0;
    int unsigned        idle_cycles = 0;
    bit                 tx_quiet = 1'b0;

    soundex_key_encoder_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                keys.note_word(i_s_axis_tdata[7:0], i_s_axis_tdata[8], i_s_axis_tlast);
            if (o_m_axis_tvalid && i_m_axis_tready)
                keys.check_key(o_m_axis_tdata, o_m_axis_tuser);
        end
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic present, input logic last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, present, b};
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (present || last) words_sent++;
    endtask

    task automatic send_text(input string s, input bit end_only);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b1, !end_only && i == s.len() - 1);
        if (end_only) send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // receiver: random back-pressure, one long hold-off to fill the pipe
    initial begin
        int          stall;
        int unsigned taken;
        bit          rx_quiet;
        taken    = 0;
        rx_quiet = 1'b0;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 16 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            stall = (taken == 60) ? HOLD_OFF : (rx_quiet ? 0 : $urandom_range(0, 4));
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            taken++;
        end
    end

    initial begin
        string       pool;
        int          len;
        int          kind;
        logic [7:0]  b;
        logic        p;
        bit          end_only;
        pool = "HWBPFVCGKSAYE";
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(8'h00, 1'b0, 1'b1);          // empty string
        send_text("z", 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);          // bytes but no letters
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hA5, 1'b0, 1'b0);          // no byte, no end
        send_text("Ashcroft", 1'b0);           // H between equal codes, key overflow
        send_text("@A[Z`a{z", 1'b1);           // letter range edges, end-only word

        while (words_sent < WORD_TARGET) begin
            tx_quiet = ($urandom_range(0, 7) == 0);
            len      = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                   : $urandom_range(0, 9);
            end_only = (len == 0) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
                kind = $urandom_range(0, 19);
                p    = 1'b1;
                if (kind < 12)
                    b = ($urandom_range(0, 1) ? ASCII_LC_A : ASCII_UC_A)
                        + 8'($urandom_range(0, 25));
                else if (kind < 16)
                    b = pool[$urandom_range(0, pool.len() - 1)]
                        | ($urandom_range(0, 1) ? CASE_OFFSET : 8'h00);
                else if (kind < 19)
                    b = 8'($urandom);
                else begin
                    b = 8'($urandom);
                    p = 1'b0;
                end
                send_word(b, p, !end_only && i == len - 1);
            end
            if (end_only) send_word(8'($urandom), 1'b0, 1'b1);
        end

        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tlast  <= 1'b0;
        @(posedge i_clk);
        while (keys.pending_keys.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (keys.bad_keys == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

/* soundex_key_encoder_unit.f */
design/sdx_pkg.sv
design/sdx_front.sv
design/sdx_queue.sv
design/sdx_back.sv
design/soundex_key_encoder_unit.sv
tb/sv/tb_soundex_key_encoder_unit.sv
